// File: src/bqc_pkg.sv
// ----------------------------------------------------------------------------
// bqc_pkg - shared types and microcode for the biquad cascade
// Control word layout, sequencer states and the per-stage microprogram.
// ----------------------------------------------------------------------------
package bqc_pkg;

   localparam int NUM_STAGES = 4;
   localparam int STAGE_W    = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int STEP_W     = 4;

   // Register kind selected by the low bit of the register index
   localparam logic REG_KIND_FORWARD = 1'b0;
   localparam logic REG_KIND_BACK    = 1'b1;

   // Microprogram step addresses (one pass per stage)
   localparam logic [STEP_W-1:0] STEP_FB_A1   = 4'd0;
   localparam logic [STEP_W-1:0] STEP_FB_A2   = 4'd1;
   localparam logic [STEP_W-1:0] STEP_FB_DONE = 4'd2;
   localparam logic [STEP_W-1:0] STEP_W_LATCH = 4'd3;
   localparam logic [STEP_W-1:0] STEP_FF_B0   = 4'd4;
   localparam logic [STEP_W-1:0] STEP_FF_B1   = 4'd5;
   localparam logic [STEP_W-1:0] STEP_FF_B2   = 4'd6;
   localparam logic [STEP_W-1:0] STEP_FF_DONE = 4'd7;
   localparam logic [STEP_W-1:0] STEP_Y_LATCH = 4'd8;
   localparam logic [STEP_W-1:0] STEP_BYPASS  = 4'd9;

   typedef enum logic {
      SEQ_IDLE,
      SEQ_RUN
   } seq_state_type;

   typedef enum logic [2:0] {
      COEF_A1,
      COEF_A2,
      COEF_B0,
      COEF_B1,
      COEF_B2
   } coef_sel_type;

   typedef enum logic [1:0] {
      OPND_D1,
      OPND_D2,
      OPND_W
   } opnd_sel_type;

   typedef enum logic [2:0] {
      ACC_HOLD,
      ACC_LOAD_X,
      ACC_LOAD_HALF,
      ACC_ADD,
      ACC_SUB
   } acc_op_type;

   typedef struct packed {
      logic         mul_en;      // register a new product
      coef_sel_type coef_sel;
      opnd_sel_type opnd_sel;
      acc_op_type   acc_op;      // acts on the product registered last step
      logic         latch_w;     // w <= sat(acc >> F)
      logic         latch_y;     // x <= sat(acc >> F), shift delays
      logic         skip_if_off; // jump to bypass step when stage disabled
      logic         end_stage;   // advance to next stage, restart program
   } ctrl_word_type;

   localparam ctrl_word_type CTRL_NOP = '{
      mul_en:      1'b0,
      coef_sel:    COEF_A1,
      opnd_sel:    OPND_D1,
      acc_op:      ACC_HOLD,
      latch_w:     1'b0,
      latch_y:     1'b0,
      skip_if_off: 1'b0,
      end_stage:   1'b0
   };

   // Microprogram ROM
   function automatic ctrl_word_type ucode(input logic [STEP_W-1:0] step);
      ctrl_word_type cw;
      cw = CTRL_NOP;
      case (step)
         STEP_FB_A1: begin
            cw.acc_op      = ACC_LOAD_X;
            cw.mul_en      = 1'b1;
            cw.coef_sel    = COEF_A1;
            cw.opnd_sel    = OPND_D1;
            cw.skip_if_off = 1'b1;
         end
         STEP_FB_A2: begin
            cw.acc_op   = ACC_SUB;
            cw.mul_en   = 1'b1;
            cw.coef_sel = COEF_A2;
            cw.opnd_sel = OPND_D2;
         end
         STEP_FB_DONE: begin
            cw.acc_op = ACC_SUB;
         end
         STEP_W_LATCH: begin
            cw.latch_w = 1'b1;
            cw.acc_op  = ACC_LOAD_HALF;
         end
         STEP_FF_B0: begin
            cw.mul_en   = 1'b1;
            cw.coef_sel = COEF_B0;
            cw.opnd_sel = OPND_W;
         end
         STEP_FF_B1: begin
            cw.acc_op   = ACC_ADD;
            cw.mul_en   = 1'b1;
            cw.coef_sel = COEF_B1;
            cw.opnd_sel = OPND_D1;
         end
         STEP_FF_B2: begin
            cw.acc_op   = ACC_ADD;
            cw.mul_en   = 1'b1;
            cw.coef_sel = COEF_B2;
            cw.opnd_sel = OPND_D2;
         end
         STEP_FF_DONE: begin
            cw.acc_op = ACC_ADD;
         end
         STEP_Y_LATCH: begin
            cw.latch_y   = 1'b1;
            cw.end_stage = 1'b1;
         end
         STEP_BYPASS: begin
            cw.end_stage = 1'b1;
         end
         default: begin
            cw.end_stage = 1'b1;
         end
      endcase
      return cw;
   endfunction

endpackage

// File: src/four_stage_biquad_cascade_top.sv
// ----------------------------------------------------------------------------
// four_stage_biquad_cascade_top - mono four-stage biquad cascade
// Averages left/right to mono and runs four configurable DF2 biquads
// through one shared multiplier under a microcoded sequencer.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  req     | in        | tvalid / tready    | tdata: sample_left, sample_right
//  rsp     | out       | tvalid / tready    | tdata: filtered_sample
//  csr     | in        | wr_en (no wait)    | index, wdata
//
//  Sequence: a transaction is accepted, then each enabled stage runs the full
//  microprogram and each bypassed stage jumps to the bypass step; the pace is
//  set by the single multiplier (five products per stage, each registered before accumulation).
//  Reset: synchronous; coefficient registers return to b0 = 1.0, delays clear.
//  Stalls: input is taken only while the sequencer is idle; a result waits in
//  the output register while the next transaction is accepted. The final
//  stage holds if the previous result has not yet been taken.
//
module four_stage_biquad_cascade_top #(
   parameter int SAMPLE_BITS    = 24,
   parameter int COEF_FRAC_BITS = 18,
   parameter int DELAY_BITS     = 32,
   localparam int COEF_BITS     = COEF_FRAC_BITS + 2,
   localparam int FWD_W         = 3 * COEF_BITS + 1,
   localparam int REQ_W         = ((2 * SAMPLE_BITS + 7) / 8) * 8,
   localparam int RSP_W         = ((SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                          clock,
   input  logic                          reset,
   // req stream
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [REQ_W-1:0]              req_tdata,  // sample_left, sample_right
   // rsp stream
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [RSP_W-1:0]              rsp_tdata,  // filtered_sample
   // configuration writes
   input  logic                          csr_wr_en,
   input  logic [bqc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [FWD_W-1:0]              csr_wdata
);

   localparam int BACK_W  = 2 * COEF_BITS;
   localparam int PROD_W  = COEF_BITS + DELAY_BITS;
   localparam int BASE_W  = (SAMPLE_BITS + COEF_FRAC_BITS > PROD_W) ?
                            SAMPLE_BITS + COEF_FRAC_BITS : PROD_W;
   localparam int ACC_W   = BASE_W + 3;
   localparam int Q_W     = ACC_W - COEF_FRAC_BITS;

   localparam logic [FWD_W-1:0] FWD_RESET =
      {{(FWD_W-COEF_FRAC_BITS-1){1'b0}}, 1'b1, {COEF_FRAC_BITS{1'b0}}};
   localparam logic signed [ACC_W-1:0] HALF =
      {{(ACC_W-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};
   localparam logic signed [Q_W-1:0] D_MAX =
      {{(Q_W-DELAY_BITS+1){1'b0}}, {(DELAY_BITS-1){1'b1}}};
   localparam logic signed [Q_W-1:0] D_MIN =
      {{(Q_W-DELAY_BITS+1){1'b1}}, {(DELAY_BITS-1){1'b0}}};
   localparam logic signed [Q_W-1:0] S_MAX =
      {{(Q_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [Q_W-1:0] S_MIN =
      {{(Q_W-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic [bqc_pkg::STAGE_W-1:0] LAST_STAGE =
      bqc_pkg::STAGE_W'(bqc_pkg::NUM_STAGES - 1);

   // Configuration and filter state
   logic [FWD_W-1:0]             fwd_ff [bqc_pkg::NUM_STAGES];
   logic [BACK_W-1:0]            back_ff [bqc_pkg::NUM_STAGES];
   logic signed [DELAY_BITS-1:0] d1_ff [bqc_pkg::NUM_STAGES];
   logic signed [DELAY_BITS-1:0] d2_ff [bqc_pkg::NUM_STAGES];

   // Sequencer and datapath registers
   bqc_pkg::seq_state_type        state_ff, state_in;
   logic [bqc_pkg::STEP_W-1:0]    step_ff, step_in;
   logic [bqc_pkg::STAGE_W-1:0]   stage_ff, stage_in;
   logic signed [SAMPLE_BITS-1:0] x_ff, x_in;
   logic signed [DELAY_BITS-1:0]  w_ff, w_in;
   logic signed [PROD_W-1:0]      prod_ff, prod_in;
   logic signed [ACC_W-1:0]       acc_ff, acc_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_data_ff, rsp_data_in;

   bqc_pkg::ctrl_word_type        cw;
   logic                          stage_on;
   logic                          last_stage;
   logic                          stall;
   logic                          advance;
   logic                          req_xfer;
   logic signed [SAMPLE_BITS:0]   lr_sum;
   logic signed [SAMPLE_BITS-1:0] mono;
   logic signed [COEF_BITS-1:0]   coef_opnd;
   logic signed [DELAY_BITS-1:0]  data_opnd;
   logic signed [ACC_W-1:0]       prod_ext;
   logic signed [Q_W-1:0]         acc_q;
   logic signed [DELAY_BITS-1:0]  w_sat;
   logic signed [SAMPLE_BITS-1:0] y_sat;
   logic signed [SAMPLE_BITS-1:0] stage_out;

   // Configuration register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < bqc_pkg::NUM_STAGES; i++) begin
            fwd_ff[i]  <= FWD_RESET;
            back_ff[i] <= '0;
         end
      end else if (csr_wr_en) begin
         if (csr_index[0] == bqc_pkg::REG_KIND_FORWARD) begin
            fwd_ff[csr_index[bqc_pkg::CSR_IDX_W-1:1]] <= csr_wdata;
         end else begin
            back_ff[csr_index[bqc_pkg::CSR_IDX_W-1:1]] <= csr_wdata[BACK_W-1:0];
         end
      end
   end

   // Decode current microword and stage status
   assign cw         = bqc_pkg::ucode(step_ff);
   assign stage_on   = fwd_ff[stage_ff][3*COEF_BITS];
   assign last_stage = (stage_ff == LAST_STAGE);
   assign stall      = cw.end_stage && last_stage && rsp_valid_ff && !rsp_tready;
   assign advance    = (state_ff == bqc_pkg::SEQ_RUN) && !stall;
   assign req_tready = (state_ff == bqc_pkg::SEQ_IDLE);
   assign req_xfer   = req_tvalid && req_tready;

   // Mono average, floor of (left + right) / 2
   assign lr_sum = {req_tdata[SAMPLE_BITS-1], req_tdata[SAMPLE_BITS-1:0]}
                 + {req_tdata[2*SAMPLE_BITS-1], req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]};
   assign mono   = lr_sum[SAMPLE_BITS:1];

   // Shared multiplier operand selection
   always_comb begin
      case (cw.coef_sel)
         bqc_pkg::COEF_A1: coef_opnd = back_ff[stage_ff][0 +: COEF_BITS];
         bqc_pkg::COEF_A2: coef_opnd = back_ff[stage_ff][COEF_BITS +: COEF_BITS];
         bqc_pkg::COEF_B0: coef_opnd = fwd_ff[stage_ff][0 +: COEF_BITS];
         bqc_pkg::COEF_B1: coef_opnd = fwd_ff[stage_ff][COEF_BITS +: COEF_BITS];
         bqc_pkg::COEF_B2: coef_opnd = fwd_ff[stage_ff][2*COEF_BITS +: COEF_BITS];
         default:          coef_opnd = '0;
      endcase
      case (cw.opnd_sel)
         bqc_pkg::OPND_D1: data_opnd = d1_ff[stage_ff];
         bqc_pkg::OPND_D2: data_opnd = d2_ff[stage_ff];
         bqc_pkg::OPND_W:  data_opnd = w_ff;
         default:          data_opnd = '0;
      endcase
   end

   assign prod_in  = coef_opnd * data_opnd;
   assign prod_ext = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};

   // Round-half-up result is the floor of (acc + half) / 2^F; half is preloaded
   assign acc_q = acc_ff[ACC_W-1:COEF_FRAC_BITS];
   assign w_sat = (acc_q > D_MAX) ? D_MAX[DELAY_BITS-1:0] :
                  (acc_q < D_MIN) ? D_MIN[DELAY_BITS-1:0] : acc_q[DELAY_BITS-1:0];
   assign y_sat = (acc_q > S_MAX) ? S_MAX[SAMPLE_BITS-1:0] :
                  (acc_q < S_MIN) ? S_MIN[SAMPLE_BITS-1:0] : acc_q[SAMPLE_BITS-1:0];
   assign stage_out = cw.latch_y ? y_sat : x_ff;

   // Sequencer next state, datapath next values
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      stage_in     = stage_ff;
      x_in         = x_ff;
      w_in         = w_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         bqc_pkg::SEQ_IDLE: begin
            if (req_xfer) begin
               x_in     = mono;
               step_in  = bqc_pkg::STEP_FB_A1;
               stage_in = '0;
               state_in = bqc_pkg::SEQ_RUN;
            end
         end
         bqc_pkg::SEQ_RUN: begin
            if (advance) begin
               case (cw.acc_op)
                  bqc_pkg::ACC_LOAD_X: acc_in =
                     {{(ACC_W-SAMPLE_BITS-COEF_FRAC_BITS){x_ff[SAMPLE_BITS-1]}},
                      x_ff, {COEF_FRAC_BITS{1'b0}}} + HALF;
                  bqc_pkg::ACC_LOAD_HALF: acc_in = HALF;
                  bqc_pkg::ACC_ADD:       acc_in = acc_ff + prod_ext;
                  bqc_pkg::ACC_SUB:       acc_in = acc_ff - prod_ext;
                  default:                acc_in = acc_ff;
               endcase
               if (cw.latch_w) begin
                  w_in = w_sat;
               end
               if (cw.latch_y) begin
                  x_in = y_sat;
               end
               if (cw.end_stage) begin
                  step_in  = bqc_pkg::STEP_FB_A1;
                  stage_in = stage_ff + 1'b1;
                  if (last_stage) begin
                     state_in     = bqc_pkg::SEQ_IDLE;
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = stage_out;
                  end
               end else if (cw.skip_if_off && !stage_on) begin
                  step_in = bqc_pkg::STEP_BYPASS;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = bqc_pkg::SEQ_IDLE;
         end
      endcase
   end

   // Sequencer control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bqc_pkg::SEQ_IDLE;
         step_ff      <= bqc_pkg::STEP_FB_A1;
         stage_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         stage_ff     <= stage_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      w_ff        <= w_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
      if (advance && cw.mul_en) begin
         prod_ff <= prod_in;
      end
   end

   // Delay line update at the end of an enabled stage
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < bqc_pkg::NUM_STAGES; i++) begin
            d1_ff[i] <= '0;
            d2_ff[i] <= '0;
         end
      end else if (advance && cw.latch_y) begin
         d1_ff[stage_ff] <= w_ff;
         d2_ff[stage_ff] <= d1_ff[stage_ff];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W-SAMPLE_BITS){1'b0}}, rsp_data_ff};

   // A new result appears only as the sequencer finishes a run
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == bqc_pkg::SEQ_RUN))
      else $error("result raised without a finishing run");

   // Program counter stays within the microprogram
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == bqc_pkg::SEQ_RUN) |-> (step_ff <= bqc_pkg::STEP_BYPASS))
      else $error("step counter outside program");

   // Idle sequencer sits at the program start on stage zero
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == bqc_pkg::SEQ_IDLE) |-> (step_ff == bqc_pkg::STEP_FB_A1 &&
                                           stage_ff == '0))
      else $error("idle sequencer not at program start");

   // A stall at the output freezes the sequencer
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == bqc_pkg::SEQ_RUN && stall) |=>
         ($stable(step_ff) && $stable(stage_ff) && state_ff == bqc_pkg::SEQ_RUN))
      else $error("sequencer moved during output stall");

endmodule

// File: dv/four_stage_biquad_cascade_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_stage_biquad_cascade_top_test - self-checking bench for the cascade
// Drives stereo sample pairs under random gaps and output stalls. A model of
// the fixed-point DF2 cascade predicts every filtered sample, and each result
// transaction is compared against the oldest prediction. The bench moves
// through several coefficient setups, including all-zero and all-one writes.
// ----------------------------------------------------------------------------
module four_stage_biquad_cascade_top_test;

   localparam int HALF_PERIOD = 1;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int PHASE_ITEMS = 250;
   localparam int NUM_PHASES  = 8;
   localparam int TAIL_CYCLES = 40;

   typedef enum int {
      SETUP_STABLE,
      SETUP_RAW,
      SETUP_ONES,
      SETUP_ZERO
   } setup_kind_type;

   // --------------------------------------------------------------------------
   // Scoreboard: fixed-point model of the cascade plus the expected queue
   // --------------------------------------------------------------------------
   class biquad_scoreboard_type;
      localparam int FRAC     = 18;
      localparam int CBITS    = FRAC + 2;
      localparam int DBITS    = 32;
      localparam int SBITS    = 24;
      localparam int STAGES   = 4;

      logic [60:0]  fwd_reg [STAGES];
      logic [39:0]  back_reg[STAGES];
      longint       dly_one [STAGES];
      longint       dly_two [STAGES];
      logic [23:0]  expected_samples[$];
      int           errors;
      int           checked;

      function new();
         for (int s = 0; s < STAGES; s++) begin
            fwd_reg[s]  = 61'(longint'(1) <<< FRAC);
            back_reg[s] = '0;
            dly_one[s]  = 0;
            dly_two[s]  = 0;
         end
         errors  = 0;
         checked = 0;
      endfunction

      function void report(string msg);
         $display("[%0t] ERROR: %s", $realtime, msg);
         errors++;
      endfunction

      function int pending();
         return expected_samples.size();
      endfunction

      // Bits above the register width are dropped
      function void set_reg(logic [bqc_pkg::CSR_IDX_W-1:0] idx, logic [60:0] value);
         int s;
         s = int'(idx[bqc_pkg::CSR_IDX_W-1:1]);
         if (idx[0] == bqc_pkg::REG_KIND_FORWARD) begin
            fwd_reg[s] = value;
         end else begin
            back_reg[s] = value[39:0];
         end
      endfunction

      static function longint coef_at(logic [60:0] r, int slot);
         logic signed [CBITS-1:0] c;
         c = r[slot*CBITS +: CBITS];
         return longint'(c);
      endfunction

      static function longint saturate(longint v, int bits);
         longint hi;
         longint lo;
         hi = (longint'(1) <<< (bits - 1)) - 1;
         lo = -hi - 1;
         if (v > hi) return hi;
         if (v < lo) return lo;
         return v;
      endfunction

      // One enabled DF2 section; sums are exact, then rounded half up
      function longint filter_stage(int s, longint x);
         longint b0, b1, b2, a1, a2, half, acc, w, y;
         b0   = coef_at(fwd_reg[s], 0);
         b1   = coef_at(fwd_reg[s], 1);
         b2   = coef_at(fwd_reg[s], 2);
         a1   = coef_at({21'd0, back_reg[s]}, 0);
         a2   = coef_at({21'd0, back_reg[s]}, 1);
         half = longint'(1) <<< (FRAC - 1);
         acc  = (x <<< FRAC) - a1 * dly_one[s] - a2 * dly_two[s] + half;
         w    = saturate(acc >>> FRAC, DBITS);
         acc  = b0 * w + b1 * dly_one[s] + b2 * dly_two[s] + half;
         y    = saturate(acc >>> FRAC, SBITS);
         dly_two[s] = dly_one[s];
         dly_one[s] = w;
         return y;
      endfunction

      function void note_input(logic [23:0] left, logic [23:0] right);
         logic signed [23:0] ls;
         logic signed [23:0] rs;
         longint             v;
         ls = left;
         rs = right;
         v  = (longint'(ls) + longint'(rs)) >>> 1;
         for (int s = 0; s < STAGES; s++) begin
            if (fwd_reg[s][3*CBITS]) begin
               v = filter_stage(s, v);
            end
         end
         expected_samples.push_back(v[23:0]);
      endfunction

      function void check_result(logic [23:0] got);
         logic [23:0] want;
         if (expected_samples.size() == 0) begin
            report($sformatf("unexpected result transaction, sample %06h", got));
            return;
         end
         want = expected_samples.pop_front();
         checked++;
         if (got !== want) begin
            report($sformatf("filtered_sample got %06h expected %06h (result %0d)",
                             got, want, checked));
         end
      endfunction
   endclass

   // --------------------------------------------------------------------------
   // DUT signals; the driven inputs are known from time zero
   // --------------------------------------------------------------------------
   logic                          clock      = 1'b0;
   logic                          reset      = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [47:0]                   req_tdata  = '0;   // sample_left, sample_right
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [23:0]                   rsp_tdata;         // filtered_sample
   logic                          csr_wr_en  = 1'b0;
   logic [bqc_pkg::CSR_IDX_W-1:0] csr_index  = '0;
   logic [60:0]                   csr_wdata  = '0;

   biquad_scoreboard_type sb;
   logic [60:0]      cfg_fwd [4];
   logic [39:0]      cfg_back[4];
   bit               gaps_on   = 1'b0;
   bit               stalls_on = 1'b0;
   int               stall_left = 0;
   int               cycle_count = 0;
   int               samples_sent = 0;
   int               results_seen = 0;
   int               setups_done = 0;

   four_stage_biquad_cascade_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // Idle lengths: mostly none or short, now and then long
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   // Cycle limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Result side backpressure
   always @(posedge clock) begin
      int n;
      n = 0;
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         if (stalls_on) n = idle_length();
         if (n > 0) begin
            stall_left <= n - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_result(rsp_tdata);
         results_seen <= results_seen + 1;
      end
   end

   // --------------------------------------------------------------------------
   // Drivers
   // --------------------------------------------------------------------------
   task automatic send_sample(logic [23:0] left, logic [23:0] right);
      int gap;
      gap = gaps_on ? idle_length() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {right, left};
      do @(posedge clock); while (!req_tready);
      sb.note_input(left, right);
      samples_sent++;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (sb.pending() > 0) @(posedge clock);
   endtask

   // Writes all eight registers; back-register writes carry junk above bit 39
   task automatic write_config();
      logic [bqc_pkg::CSR_IDX_W-1:0] idx;
      logic [60:0]                   wd;
      for (int s = 0; s < 4; s++) begin
         idx = {2'(s), bqc_pkg::REG_KIND_FORWARD};
         wd  = cfg_fwd[s];
         csr_wr_en <= 1'b1;
         csr_index <= idx;
         csr_wdata <= wd;
         @(posedge clock);
         sb.set_reg(idx, wd);
         idx = {2'(s), bqc_pkg::REG_KIND_BACK};
         wd  = {21'($urandom), cfg_back[s]};
         csr_index <= idx;
         csr_wdata <= wd;
         @(posedge clock);
         sb.set_reg(idx, wd);
      end
      csr_wr_en <= 1'b0;
      setups_done++;
   endtask

   function automatic logic [60:0] pack_forward(bit en, int b0, int b1, int b2);
      return {en, 20'(b2), 20'(b1), 20'(b0)};
   endfunction

   function automatic logic [39:0] pack_back(int a1, int a2);
      return {20'(a2), 20'(a1)};
   endfunction

   // Coefficient setups for the random phases
   function automatic void choose_setup(setup_kind_type kind);
      int a1, a2, lim, b0, b1, b2;
      for (int s = 0; s < 4; s++) begin
         case (kind)
            SETUP_STABLE: begin
               // poles inside the stability triangle, moderate gains
               a2  = $urandom_range(0, 2 * 235929) - 235929;
               lim = ((262144 + a2) * 15) / 16;
               a1  = $urandom_range(0, 2 * lim) - lim;
               if ($urandom_range(0, 7) == 0) begin
                  b0 = $urandom_range(0, 1048575) - 524288;
                  b1 = $urandom_range(0, 1048575) - 524288;
                  b2 = $urandom_range(0, 1048575) - 524288;
               end else begin
                  b0 = $urandom_range(0, 524287) - 262144;
                  b1 = $urandom_range(0, 524287) - 262144;
                  b2 = $urandom_range(0, 524287) - 262144;
               end
               cfg_fwd[s]  = pack_forward($urandom_range(0, 3) != 0, b0, b1, b2);
               cfg_back[s] = pack_back(a1, a2);
            end
            SETUP_RAW: begin
               cfg_fwd[s]  = 61'({$urandom, $urandom});
               cfg_back[s] = 40'({$urandom, $urandom});
            end
            SETUP_ONES: begin
               cfg_fwd[s]  = '1;
               cfg_back[s] = '1;
            end
            default: begin
               cfg_fwd[s]  = '0;
               cfg_back[s] = '0;
            end
         endcase
      end
   endfunction

   function automatic logic [23:0] random_sample();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 24'h7FFFFF;
      if (r == 1) return 24'h800000;
      if (r < 6) return 24'($urandom);
      return 24'($urandom_range(0, 8191) - 4096);
   endfunction

   // --------------------------------------------------------------------------
   // Main sequence
   // --------------------------------------------------------------------------
   initial begin
      logic [23:0] l;
      logic [23:0] r;
      setup_kind_type plan[NUM_PHASES];
      plan = '{SETUP_STABLE, SETUP_RAW, SETUP_STABLE, SETUP_ONES,
               SETUP_STABLE, SETUP_ZERO, SETUP_STABLE, SETUP_RAW};
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset coefficients: every stage bypassed, output is the floored mean
      send_sample(24'h7FFFFF, 24'h7FFFFF);
      send_sample(24'h800000, 24'h800000);
      send_sample(24'h7FFFFF, 24'h800000);
      send_sample(24'hAAAAAA, 24'h555555);
      send_sample(24'h555555, 24'hAAAAAA);
      send_sample(24'h000001, 24'h000000);
      send_sample(24'hFFFFFF, 24'h000000);
      send_sample(24'h000000, 24'h000000);
      drain();

      // Stage 0 only, as a plain gain of b0 = 0.5: rounding ties go toward plus infinity
      for (int s = 0; s < 4; s++) begin
         cfg_fwd[s]  = pack_forward(1'b0, 262144, 0, 0);
         cfg_back[s] = '0;
      end
      cfg_fwd[0] = pack_forward(1'b1, 131072, 0, 0);
      write_config();
      send_sample(24'h000001, 24'h000001);
      send_sample(24'hFFFFFF, 24'hFFFFFF);
      send_sample(24'h000003, 24'h000003);
      send_sample(24'h7FFFFF, 24'h7FFFFF);
      drain();

      // All stages on with extreme coefficients: delay and output saturation
      for (int s = 0; s < 4; s++) begin
         cfg_fwd[s]  = pack_forward(1'b1, -524288, -524288, -524288);
         cfg_back[s] = pack_back(524287, -524288);
      end
      write_config();
      send_sample(24'h7FFFFF, 24'h7FFFFF);
      send_sample(24'h800000, 24'h800000);
      send_sample(24'h7FFFFF, 24'h7FFFFF);
      send_sample(24'h000000, 24'h000000);
      send_sample(24'h800000, 24'h800000);
      send_sample(24'h000001, 24'h000000);
      drain();

      // Random phases, each under its own setup and idling mix
      for (int p = 0; p < NUM_PHASES; p++) begin
         choose_setup(plan[p]);
         write_config();
         gaps_on   = (p != 0) && ($urandom_range(0, 3) != 0);
         stalls_on = (p != 0) && ($urandom_range(0, 3) != 0);
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            l = random_sample();
            r = ($urandom_range(0, 3) == 0) ? l : random_sample();
            send_sample(l, r);
         end
         drain();
      end

      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.pending() != 0) begin
         sb.report($sformatf("%0d expected samples never arrived", sb.pending()));
      end

      $display("Covered %0d sample pairs and %0d filtered results across %0d setups,",
               samples_sent, results_seen, setups_done);
      $display("from bypass and rounding cases to saturating and random coefficients.");
      if (sb.errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
